FILE: sv/psmpd_pkg.sv
// package for the pulse symbol manchester packet decoder
// holds payload structs, symbol and status codes, reset values of the config registers
// no dependencies
package psmpd_pkg;

    localparam int unsigned OUTQ_DEPTH = 4;

    localparam logic [7:0] MIN_SYMBOL_RESET = 8'd96;
    localparam logic [7:0] MIN_BIT_RESET    = 8'd48;
    localparam logic [3:0] HEADER_RESET     = 4'd10;

    typedef enum logic [2:0] {
        SYM_SHORT_PAUSE = 3'd0,
        SYM_SHORT_PULSE = 3'd1,
        SYM_LONG_PAUSE  = 3'd2,
        SYM_LONG_PULSE  = 3'd3,
        SYM_END_GAP     = 3'd4,
        SYM_UNKNOWN     = 3'd5,
        SYM_OTHER_UPPER = 3'd6,
        SYM_OTHER_LOWER = 3'd7
    } t_symbol;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_FEW_SYMBOLS   = 3'd1,
        ST_NOT_ALTERNATE = 3'd2,
        ST_BAD_SEQUENCE  = 3'd3,
        ST_FEW_BITS      = 3'd4,
        ST_CHECKSUM      = 3'd5,
        ST_HEADER        = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PARTNER_NONE       = 2'd0,
        PARTNER_LONG_PAUSE = 2'd1,
        PARTNER_LONG_PULSE = 2'd2
    } t_partner;

    typedef enum logic [1:0] {
        CFG_MIN_SYMBOLS = 2'd0,
        CFG_MIN_BITS    = 2'd1,
        CFG_HEADER      = 2'd2
    } t_cfg_index;

    localparam logic KIND_NIBBLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [2:0] symbol;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] nibble_value;
        logic [2:0] status;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [7:0] min_symbol_count;
        logic [7:0] min_bit_count;
        logic [3:0] header_nibble;
    } t_cfg;

endpackage

FILE: sv/pulse_symbol_manchester_packet_decoder.sv
// path: a taken symbol is held in the input stage, and its results are registered in the result queue
// throughput: one symbol per cycle; a symbol that gives a nibble and a status puts two
// results into the queue, which drains one per cycle, so input stalls only on output back-pressure
// reset: synchronous active low; clears the packet state and the queue, config back to 96/48/10
// depends on psmpd_pkg, psmpd_core, psmpd_outq
module pulse_symbol_manchester_packet_decoder
    import psmpd_pkg::*;
#(
    parameter int unsigned P_OUTQ_DEPTH = OUTQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    t_cfg       r_cfg;
    logic       fire;
    logic       space2;
    logic [1:0] push_n;
    t_result    res0, res1;

    assign fire        = r_in_valid && space2;
    assign o_ready     = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_symbol_count <= MIN_SYMBOL_RESET;
            r_cfg.min_bit_count    <= MIN_BIT_RESET;
            r_cfg.header_nibble    <= HEADER_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MIN_SYMBOLS: r_cfg.min_symbol_count <= i_cfg_data;
                CFG_MIN_BITS:    r_cfg.min_bit_count    <= i_cfg_data;
                CFG_HEADER:      r_cfg.header_nibble    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    psmpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_push_n (push_n),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    psmpd_outq #(
        .DEPTH (P_OUTQ_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_space2 (space2),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in)))
        else $error("staged symbol lost while stalled");

    a_push_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> fire)
        else $error("result pushed without a staged symbol");

    a_eop_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.end_of_packet) |-> (push_n != 2'd0))
        else $error("packet end without a status result");

endmodule

FILE: sv/psmpd_outq.sv
// result queue of the packet decoder: takes up to two results a cycle, gives one
// registered entries, read at the head pointer
// depends on psmpd_pkg
module psmpd_outq
    import psmpd_pkg::*;
#(
    parameter int unsigned DEPTH = OUTQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_space2,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   wp1, wp2;
    logic            pop;

    assign wp1 = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign wp2 = (wp1 == LAST) ? '0 : wp1 + 1'b1;
    assign pop = o_valid && i_ready;

    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rp];
    assign o_space2 = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push_n == 2'd1) begin
            n_wp = wp1;
        end else if (i_push_n == 2'd2) begin
            n_wp = wp2;
        end
        if (pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        n_count = r_count + CW'(i_push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> (32'(r_count) + 32'(i_push_n) <= DEPTH))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd0 && !pop) |=> (r_count == $past(r_count)))
        else $error("queue count moved without a transaction");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |=> o_valid)
        else $error("pushed result not visible");

endmodule

FILE: sv/psmpd_core.sv
// packet state of the decoder: alternation, manchester bit decode, nibble window,
// checksum and final status, updated once per staged symbol
// depends on psmpd_pkg
module psmpd_core
    import psmpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    output logic [1:0] o_push_n,
    output t_result    o_res0,
    output t_result    o_res1
);

    logic [7:0]  r_sym_count, n_sym_count;
    logic        r_stopped, n_stopped;
    logic        r_have_prev, n_have_prev;
    logic        r_prev_pulse, n_prev_pulse;
    t_partner    r_partner, n_partner;
    logic        r_half, n_half;
    logic [2:0]  r_partial, n_partial;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_bit_count, n_bit_count;
    logic [3:0]  r_win [4];
    logic [3:0]  n_win [4];
    logic [2:0]  r_fill, n_fill;
    logic        r_first_done, n_first_done;
    logic [3:0]  r_first, n_first;
    logic [15:0] r_sum, n_sum;
    logic        r_alt_err, n_alt_err;
    logic        r_seq_err, n_seq_err;

    t_symbol     sym;
    logic        pulse;
    logic        push;
    logic        bit_val;
    logic        nib_valid;
    logic [3:0]  nib;
    logic [16:0] sum_wide;
    t_status     status;
    t_result     nib_res, st_res;

    assign sym = t_symbol'(i_item.symbol);

    always_comb begin
        n_sym_count  = (r_sym_count != 8'hFF) ? r_sym_count + 8'd1 : r_sym_count;
        n_stopped    = r_stopped;
        n_have_prev  = r_have_prev;
        n_prev_pulse = r_prev_pulse;
        n_partner    = r_partner;
        n_half       = r_half;
        n_partial    = r_partial;
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_win        = r_win;
        n_fill       = r_fill;
        n_first_done = r_first_done;
        n_first      = r_first;
        n_sum        = r_sum;
        n_alt_err    = r_alt_err;
        n_seq_err    = r_seq_err;
        pulse        = (sym == SYM_SHORT_PULSE) || (sym == SYM_LONG_PULSE) ||
                       (sym == SYM_OTHER_UPPER);
        push         = 1'b0;
        bit_val      = 1'b0;
        nib_valid    = 1'b0;
        nib          = 4'd0;
        sum_wide     = {1'b0, r_sum} + 17'(r_win[0]);

        if (!r_stopped) begin
            if (sym == SYM_END_GAP || sym == SYM_UNKNOWN) begin
                n_stopped = 1'b1;
            end else begin
                if (r_have_prev && pulse == r_prev_pulse) begin
                    n_alt_err = 1'b1;
                end
                n_have_prev  = 1'b1;
                n_prev_pulse = pulse;
                if (!r_seq_err) begin
                    if (r_partner != PARTNER_NONE) begin
                        if ((r_partner == PARTNER_LONG_PAUSE && sym == SYM_LONG_PAUSE) ||
                            (r_partner == PARTNER_LONG_PULSE && sym == SYM_LONG_PULSE)) begin
                            n_partner = PARTNER_NONE;
                        end else begin
                            n_seq_err = 1'b1;
                        end
                    end else begin
                        case (sym)
                            SYM_LONG_PAUSE, SYM_LONG_PULSE: begin
                                if (r_half) begin
                                    n_seq_err = 1'b1;
                                end else begin
                                    n_partner = (sym == SYM_LONG_PAUSE) ?
                                                PARTNER_LONG_PULSE : PARTNER_LONG_PAUSE;
                                    n_half    = 1'b1;
                                    push      = 1'b1;
                                    bit_val   = (sym == SYM_LONG_PULSE);
                                end
                            end
                            SYM_SHORT_PAUSE, SYM_SHORT_PULSE: begin
                                if (r_half) begin
                                    n_half = 1'b0;
                                end else begin
                                    n_half  = 1'b1;
                                    push    = 1'b1;
                                    bit_val = (sym == SYM_SHORT_PAUSE);
                                end
                            end
                            default: begin
                                n_seq_err = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end

        // bit append and nibble packing
        if (push) begin
            if (r_bit_count != 8'hFF) begin
                n_bit_count = r_bit_count + 8'd1;
            end
            if (r_phase == 2'd3) begin
                nib       = {bit_val, r_partial};
                nib_valid = 1'b1;
                n_partial = 3'd0;
                n_phase   = 2'd0;
            end else begin
                n_partial = r_partial | (3'(bit_val) << r_phase);
                n_phase   = r_phase + 2'd1;
            end
        end

        // sliding window of the last four nibbles, older ones but the first go into the sum
        if (nib_valid) begin
            if (r_fill == 3'd0) begin
                n_first = nib;
            end
            if (r_fill >= 3'd4) begin
                if (r_first_done) begin
                    n_sum = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
                end else begin
                    n_first_done = 1'b1;
                end
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
                n_win[2] = r_win[3];
                n_win[3] = nib;
            end else begin
                n_win[r_fill[1:0]] = nib;
                n_fill = r_fill + 3'd1;
            end
        end

        if (n_sym_count < i_cfg.min_symbol_count) begin
            status = ST_FEW_SYMBOLS;
        end else if (n_alt_err) begin
            status = ST_NOT_ALTERNATE;
        end else if (n_seq_err) begin
            status = ST_BAD_SEQUENCE;
        end else if (n_bit_count < i_cfg.min_bit_count) begin
            status = ST_FEW_BITS;
        end else if (n_fill < 3'd4) begin
            status = ST_CHECKSUM;
        end else if (n_sum != {8'd0, n_win[1], n_win[0]}) begin
            status = ST_CHECKSUM;
        end else if (n_first != i_cfg.header_nibble) begin
            status = ST_HEADER;
        end else begin
            status = ST_OK;
        end

        // packet end clears everything back to the reset state
        if (i_item.end_of_packet) begin
            n_sym_count  = 8'd0;
            n_stopped    = 1'b0;
            n_have_prev  = 1'b0;
            n_prev_pulse = 1'b0;
            n_partner    = PARTNER_NONE;
            n_half       = 1'b0;
            n_partial    = 3'd0;
            n_phase      = 2'd1;
            n_bit_count  = 8'd1;
            n_win[0]     = 4'd0;
            n_win[1]     = 4'd0;
            n_win[2]     = 4'd0;
            n_win[3]     = 4'd0;
            n_fill       = 3'd0;
            n_first_done = 1'b0;
            n_first      = 4'd0;
            n_sum        = 16'd0;
            n_alt_err    = 1'b0;
            n_seq_err    = 1'b0;
        end
    end

    always_comb begin
        nib_res.result_kind  = KIND_NIBBLE;
        nib_res.nibble_value = nib;
        nib_res.status       = ST_OK;
        nib_res.last_of_run  = 1'b0;
        st_res.result_kind   = KIND_STATUS;
        st_res.nibble_value  = 4'd0;
        st_res.status        = status;
        st_res.last_of_run   = 1'b1;
        o_res0   = nib_valid ? nib_res : st_res;
        o_res1   = st_res;
        o_push_n = i_fire ? (2'(nib_valid) + 2'(i_item.end_of_packet)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_count  <= 8'd0;
            r_stopped    <= 1'b0;
            r_have_prev  <= 1'b0;
            r_prev_pulse <= 1'b0;
            r_partner    <= PARTNER_NONE;
            r_half       <= 1'b0;
            r_partial    <= 3'd0;
            r_phase      <= 2'd1;
            r_bit_count  <= 8'd1;
            r_win[0]     <= 4'd0;
            r_win[1]     <= 4'd0;
            r_win[2]     <= 4'd0;
            r_win[3]     <= 4'd0;
            r_fill       <= 3'd0;
            r_first_done <= 1'b0;
            r_first      <= 4'd0;
            r_sum        <= 16'd0;
            r_alt_err    <= 1'b0;
            r_seq_err    <= 1'b0;
        end else if (i_fire) begin
            r_sym_count  <= n_sym_count;
            r_stopped    <= n_stopped;
            r_have_prev  <= n_have_prev;
            r_prev_pulse <= n_prev_pulse;
            r_partner    <= n_partner;
            r_half       <= n_half;
            r_partial    <= n_partial;
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_win        <= n_win;
            r_fill       <= n_fill;
            r_first_done <= n_first_done;
            r_first      <= n_first;
            r_sum        <= n_sum;
            r_alt_err    <= n_alt_err;
            r_seq_err    <= n_seq_err;
        end
    end

    a_eop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.end_of_packet) |=>
            (r_sym_count == 8'd0 && r_bit_count == 8'd1 && r_fill == 3'd0))
        else $error("packet state not cleared at packet end");

    a_nibble_needs_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nib_valid |-> (!r_stopped && !r_seq_err && r_partner == PARTNER_NONE))
        else $error("nibble produced outside the decoded part");

    a_partner_implies_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_partner != PARTNER_NONE) |-> r_half)
        else $error("partner pending without a half bit");

endmodule

FILE: tb/pulse_symbol_manchester_packet_decoder_test.sv
// self-checking testbench for pulse_symbol_manchester_packet_decoder: Manchester framing, nibbles,
// end-of-packet status; drives symbol packets across several register settings
// depends on psmpd_pkg and the decoder RTL
module pulse_symbol_manchester_packet_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import psmpd_pkg::*;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    t_in_item   i_item      = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;

    pulse_symbol_manchester_packet_decoder i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder model: register copies and packet state
    logic [7:0]  min_symbols;
    logic [7:0]  min_bits;
    logic [3:0]  header_goal;
    logic [7:0]  seen_symbols;
    bit          decode_stopped;
    bit          have_last;
    bit          last_was_pulse;
    t_partner    partner_due;
    bit          half_open;
    logic [2:0]  bit_buffer;
    logic [1:0]  bit_slot;
    logic [7:0]  decoded_bits;
    logic [3:0]  nibble_window [4];
    logic [2:0]  window_fill;
    bit          header_skipped;
    logic [3:0]  header_seen;
    logic [15:0] nibble_sum;
    bit          bad_alternation;
    bit          bad_sequence;

    t_result  expected_results [$];
    t_in_item symbol_queue [$];

    bit         in_fire;
    bit         cfg_fire;
    int         burst_left = 0;
    int         gap_left = 0;
    logic [15:0] stall_mask = '1;
    logic [3:0]  stall_step = '0;
    int         mismatches = 0;
    int         nibbles_checked = 0;
    int         statuses_checked = 0;
    int         items_queued = 0;
    int         packets_queued = 0;
    int         settings_used = 1;

    function automatic void clear_packet();
        seen_symbols    = '0;
        decode_stopped  = 1'b0;
        have_last       = 1'b0;
        last_was_pulse  = 1'b0;
        partner_due     = PARTNER_NONE;
        half_open       = 1'b0;
        bit_buffer      = '0;
        bit_slot        = 2'd1;   // implied leading zero already in slot 0
        decoded_bits    = 8'd1;
        for (int k = 0; k < 4; k++) nibble_window[k] = '0;
        window_fill     = '0;
        header_skipped  = 1'b0;
        header_seen     = '0;
        nibble_sum      = '0;
        bad_alternation = 1'b0;
        bad_sequence    = 1'b0;
    endfunction

    function automatic void store_nibble(logic [3:0] nib);
        int total;
        if (window_fill == 0) header_seen = nib;
        if (window_fill >= 4) begin
            // the header leaves the window first and never enters the sum
            if (header_skipped) begin
                total = nibble_sum + nibble_window[0];
                nibble_sum = (total > 16'hffff) ? 16'hffff : total[15:0];
            end else begin
                header_skipped = 1'b1;
            end
            nibble_window[0] = nibble_window[1];
            nibble_window[1] = nibble_window[2];
            nibble_window[2] = nibble_window[3];
            nibble_window[3] = nib;
        end else begin
            nibble_window[window_fill[1:0]] = nib;
            window_fill++;
        end
    endfunction

    function automatic bit shift_in_bit(bit b, output logic [3:0] nib);
        nib = '0;
        if (decoded_bits != 8'hff) decoded_bits++;
        if (bit_slot == 2'd3) begin
            nib = {b, bit_buffer};
            bit_buffer = '0;
            bit_slot = 2'd0;
            store_nibble(nib);
            return 1'b1;
        end
        bit_buffer[bit_slot] = b;
        bit_slot++;
        return 1'b0;
    endfunction

    function automatic bit decode_half(t_symbol s, output logic [3:0] nib);
        t_symbol partner;
        nib = '0;
        if (partner_due != PARTNER_NONE) begin
            partner = (partner_due == PARTNER_LONG_PAUSE) ? SYM_LONG_PAUSE : SYM_LONG_PULSE;
            if (s == partner) partner_due = PARTNER_NONE;
            else bad_sequence = 1'b1;
            return 1'b0;
        end
        case (s)
            SYM_LONG_PAUSE, SYM_LONG_PULSE: begin
                if (half_open) begin
                    bad_sequence = 1'b1;
                    return 1'b0;
                end
                partner_due = (s == SYM_LONG_PAUSE) ? PARTNER_LONG_PULSE : PARTNER_LONG_PAUSE;
                half_open = 1'b1;
                return shift_in_bit(s == SYM_LONG_PULSE, nib);
            end
            SYM_SHORT_PAUSE, SYM_SHORT_PULSE: begin
                if (half_open) begin
                    half_open = 1'b0;
                    return 1'b0;
                end
                half_open = 1'b1;
                return shift_in_bit(s == SYM_SHORT_PAUSE, nib);
            end
            default: begin
                bad_sequence = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_status packet_status();
        if (seen_symbols < min_symbols) return ST_FEW_SYMBOLS;
        if (bad_alternation) return ST_NOT_ALTERNATE;
        if (bad_sequence) return ST_BAD_SEQUENCE;
        if (decoded_bits < min_bits) return ST_FEW_BITS;
        if (window_fill < 4) return ST_CHECKSUM;
        if (nibble_sum != {8'd0, nibble_window[1], nibble_window[0]}) return ST_CHECKSUM;
        if (header_seen != header_goal) return ST_HEADER;
        return ST_OK;
    endfunction

    function automatic void predict_symbol(t_in_item it);
        t_symbol    s;
        logic [3:0] nib;
        bit         pulse;
        t_result    res;
        s = t_symbol'(it.symbol);
        if (seen_symbols != 8'hff) seen_symbols++;
        if (!decode_stopped) begin
            if (s == SYM_END_GAP || s == SYM_UNKNOWN) begin
                decode_stopped = 1'b1;
            end else begin
                pulse = (s == SYM_SHORT_PULSE || s == SYM_LONG_PULSE || s == SYM_OTHER_UPPER);
                if (have_last && pulse == last_was_pulse) bad_alternation = 1'b1;
                have_last = 1'b1;
                last_was_pulse = pulse;
                if (!bad_sequence && decode_half(s, nib)) begin
                    res = '{result_kind: KIND_NIBBLE, nibble_value: nib, status: ST_OK,
                            last_of_run: 1'b0};
                    expected_results = {expected_results, res};
                end
            end
        end
        if (it.end_of_packet) begin
            res = '{result_kind: KIND_STATUS, nibble_value: 4'd0, status: packet_status(),
                    last_of_run: 1'b1};
            expected_results = {expected_results, res};
            clear_packet();
        end
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [7:0] data);
        case (t_cfg_index'(idx))
            CFG_MIN_SYMBOLS: min_symbols = data;
            CFG_MIN_BITS:    min_bits = data;
            CFG_HEADER:      header_goal = data[3:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing waiting", got, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind != want.result_kind)
            report_mismatch("result_kind", got.result_kind, want.result_kind);
        if (got.nibble_value != want.nibble_value)
            report_mismatch("nibble_value", got.nibble_value, want.nibble_value);
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (want.result_kind == KIND_NIBBLE) nibbles_checked++;
        else statuses_checked++;
    endtask

    // monitor: all three channels' transactions are taken at the rising edge
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_valid && o_ready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (in_fire) predict_symbol(i_item);
        if (cfg_fire) apply_register(i_cfg_index, i_cfg_data);
        if (i_rst_n && o_valid && i_ready) check_result(o_result);
    end

    // symbol driver: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid = 1'b0;
            end else if (symbol_queue.size() > 0) begin
                i_item = symbol_queue.pop_front();
                i_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid = 1'b0;
            end
        end
    end

    // result side stalls on a rotating 16-bit mask, reshuffled every lap
    always @(negedge i_clk) begin
        if (stall_step == 0) begin
            case ($urandom_range(0, 2))
                0: stall_mask = '1;
                1: stall_mask = 16'($urandom);
                default: stall_mask = 16'($urandom & $urandom) | 16'h0001;
            endcase
        end
        i_ready = stall_mask[stall_step];
        stall_step++;
    end

    task automatic add_symbol(t_symbol s, bit eop = 1'b0);
        t_in_item it;
        it.symbol = s;
        it.end_of_packet = eop;
        symbol_queue = {symbol_queue, it};
        items_queued++;
        if (eop) packets_queued++;
    endtask

    // one Manchester bit; last_pulse tracks the polarity of the previous symbol
    task automatic add_bit(bit b, inout bit last_pulse);
        if (last_pulse) begin
            if (b) begin
                add_symbol(SYM_SHORT_PAUSE);
                add_symbol(SYM_SHORT_PULSE);
            end else begin
                add_symbol(SYM_LONG_PAUSE);
                add_symbol(SYM_LONG_PULSE);
                add_symbol(SYM_SHORT_PAUSE);
                last_pulse = 1'b0;
            end
        end else begin
            if (!b) begin
                add_symbol(SYM_SHORT_PULSE);
                add_symbol(SYM_SHORT_PAUSE);
            end else begin
                add_symbol(SYM_LONG_PULSE);
                add_symbol(SYM_LONG_PAUSE);
                add_symbol(SYM_SHORT_PULSE);
                last_pulse = 1'b1;
            end
        end
    endtask

    // well-formed packet, mostly with a good header and checksum, sometimes damaged
    task automatic add_frame(int nibble_count);
        logic [3:0] nibs [$];
        int         sum;
        int         start;
        int         pick;
        int         tail;
        bit         last_pulse;
        sum = 0;
        start = symbol_queue.size();
        for (int k = 0; k < nibble_count; k++) nibs = {nibs, 4'($urandom)};
        if (nibble_count > 0 && $urandom_range(0, 6) != 0) nibs[0] = header_goal;
        if (nibble_count >= 5) begin
            for (int k = 1; k <= nibble_count - 5; k++) sum += nibs[k];
            nibs[nibble_count - 4] = sum[3:0];
            nibs[nibble_count - 3] = sum[7:4];
            if ($urandom_range(0, 5) == 0)
                nibs[nibble_count - 4] ^= 4'(1 << $urandom_range(0, 3));
        end
        last_pulse = $urandom_range(0, 1);
        for (int k = 0; k < nibble_count; k++)
            for (int j = (k == 0) ? 1 : 0; j < 4; j++) add_bit(nibs[k][j], last_pulse);
        // leftover bits short of a nibble
        repeat ($urandom_range(0, 3)) add_bit($urandom_range(0, 1), last_pulse);
        if ($urandom_range(0, 7) == 0 && symbol_queue.size() > start) begin
            pick = $urandom_range(start, symbol_queue.size() - 1);
            symbol_queue[pick].symbol = 3'($urandom);
        end
        tail = $urandom_range(0, 3);
        if (tail == 0 && symbol_queue.size() > start) begin
            symbol_queue[symbol_queue.size() - 1].end_of_packet = 1'b1;
            packets_queued++;
        end else begin
            // symbols after the end gap are only counted
            if (tail == 3) begin
                add_symbol(SYM_END_GAP);
                repeat ($urandom_range(1, 30)) add_symbol(t_symbol'($urandom_range(0, 7)));
            end
            add_symbol((tail == 2) ? SYM_UNKNOWN : SYM_END_GAP, 1'b1);
        end
    endtask

    task automatic add_noise();
        int len;
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++) add_symbol(t_symbol'($urandom_range(0, 7)), k == len - 1);
    endtask

    task automatic wait_idle();
        while (symbol_queue.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(int quota, int fewest, int most);
        int first;
        first = items_queued;
        while (items_queued - first < quota) begin
            if ($urandom_range(0, 4) == 0) add_noise();
            else add_frame($urandom_range(fewest, most));
        end
        wait_idle();
    endtask

    task automatic write_register(t_cfg_index idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_settings(logic [7:0] symbols, logic [7:0] bits, logic [3:0] header);
        write_register(CFG_MIN_SYMBOLS, symbols);
        write_register(CFG_MIN_BITS, bits);
        // upper data bits of the header register are don't-care
        write_register(CFG_HEADER, {4'($urandom), header});
        settings_used++;
    endtask

    initial begin
        min_symbols = MIN_SYMBOL_RESET;
        min_bits    = MIN_BIT_RESET;
        header_goal = HEADER_RESET;
        clear_packet();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // lone symbol that also ends the packet
        add_symbol(SYM_SHORT_PAUSE, 1'b1);
        // two pulses in a row, then foreign symbols
        add_symbol(SYM_SHORT_PULSE);
        add_symbol(SYM_SHORT_PULSE);
        add_symbol(SYM_OTHER_UPPER);
        add_symbol(SYM_OTHER_LOWER, 1'b1);
        // long pause followed by the wrong partner
        add_symbol(SYM_LONG_PAUSE);
        add_symbol(SYM_SHORT_PULSE, 1'b1);
        // long symbol where the second half is due
        add_symbol(SYM_SHORT_PULSE);
        add_symbol(SYM_LONG_PAUSE);
        add_symbol(SYM_LONG_PULSE, 1'b1);
        // partner still pending at packet end
        add_symbol(SYM_LONG_PULSE, 1'b1);
        // unknown stops decoding
        add_symbol(SYM_SHORT_PAUSE);
        add_symbol(SYM_UNKNOWN);
        add_symbol(SYM_SHORT_PAUSE);
        add_symbol(SYM_END_GAP, 1'b1);
        // end gap first
        add_symbol(SYM_END_GAP);
        add_symbol(SYM_LONG_PULSE, 1'b1);
        // nibble completes on the packet's last symbol
        add_symbol(SYM_SHORT_PAUSE);
        add_symbol(SYM_SHORT_PULSE);
        add_symbol(SYM_SHORT_PAUSE);
        add_symbol(SYM_SHORT_PULSE);
        add_symbol(SYM_SHORT_PAUSE, 1'b1);
        wait_idle();

        // long packet saturates the symbol counter
        add_frame(34);
        run_phase(60, 12, 14);

        write_settings(8'd0, 8'd0, {3'($urandom), 1'b0});
        run_phase(30, 0, 6);

        write_settings(8'($urandom_range(0, 120)), 8'($urandom_range(0, 60)), 4'($urandom));
        run_phase(40, 4, 8);

        write_settings(8'd0, 8'd0, 4'd0);
        run_phase(30, 5, 7);

        repeat (8) @(negedge i_clk);
        $display("sent %0d symbols in %0d packets under %0d register settings",
                 items_queued, packets_queued, settings_used);
        $display("checked %0d nibble and %0d packet status transactions, %0d mismatches",
                 nibbles_checked, statuses_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
